[rtl/sha_pkg.sv]
// Package: SHA-256 constants, types and round functions
package sha_pkg;

    localparam int unsigned QDepth = 4;
    localparam int unsigned QAw = 2;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       end_of_message;
    } t_item;

    typedef logic [31:0] t_word;

    function automatic t_word round_k(input logic [5:0] r);
        t_word k;
        case (r)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic t_word init_h(input logic [2:0] i);
        t_word h;
        case (i)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab; default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

    function automatic t_word rr(input t_word x, input int unsigned n);
        return (x >> n) | (x << (32 - n));
    endfunction

    localparam logic [7:0] PadByte = 8'h80;
    localparam logic [5:0] LenPos = 6'd56;

endpackage

[rtl/sha_stream_if.sv]
// Interface: valid/ready channel with a payload
interface sha_stream_if #(parameter int unsigned W = 1);
    logic         valid;
    logic         ready;
    logic [W-1:0] payload;
    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

[rtl/sha256_hash_engine.sv]
// Top level: SHA-256 engine, byte stream in, digest words out
//  channel | dir | payload
//  s_in    | in  | data_byte[7:0], byte_present, end_of_message
//  m_out   | out | digest_word[31:0], word_index[2:0], last_word
// The back end takes one byte item per cycle while in IDLE; a full block then
// runs 64 rounds plus the hash update, and no items are taken meanwhile. End
// of message adds padding bytes at one per cycle, one or two compressions, then
// the 8 digest words out. The input queue holds 4 items. Reset is synchronous, active low.
module sha256_hash_engine (
    input  logic        i_clk,
    input  logic        i_rst_n,
    sha_stream_if.sink   s_in,
    sha_stream_if.source m_out
);
    sha_pkg::t_item in_item, q_item;
    logic q_valid, q_pop;
    logic [31:0] dw;
    logic [2:0]  wi;
    logic        lw;

    assign in_item = sha_pkg::t_item'(s_in.payload);

    sha_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_in.valid), .o_ready(s_in.ready), .i_item(in_item),
        .o_q_valid(q_valid), .i_q_pop(q_pop), .o_q_item(q_item)
    );

    sha_core u_core (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_q_valid(q_valid), .o_q_pop(q_pop), .i_q_item(q_item),
        .o_valid(m_out.valid), .i_ready(m_out.ready),
        .o_digest_word(dw), .o_word_index(wi), .o_last_word(lw)
    );

    assign m_out.payload = {dw, wi, lw};
endmodule

[rtl/sha_front.sv]
// Front end: accepts byte items into a short queue
module sha_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  sha_pkg::t_item  i_item,
    output logic            o_q_valid,
    input  logic            i_q_pop,
    output sha_pkg::t_item  o_q_item
);
    sha_pkg::t_item r_mem [sha_pkg::QDepth];
    logic [sha_pkg::QAw-1:0] r_wp, r_rp;
    logic [sha_pkg::QAw:0]   r_cnt;
    logic push, pop;

    assign o_ready   = (r_cnt != 3'(sha_pkg::QDepth));
    assign push      = i_valid && o_ready && (i_item.byte_present || i_item.end_of_message);
    assign o_q_valid = (r_cnt != '0);
    assign pop       = i_q_pop && o_q_valid;
    assign o_q_item  = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) r_mem[r_wp] <= i_item;
        if (!i_rst_n) begin
            r_wp <= '0; r_rp <= '0; r_cnt <= '0;
        end else begin
            if (push) r_wp <= r_wp + 1'b1;
            if (pop) r_rp <= r_rp + 1'b1;
            r_cnt <= r_cnt + {2'b0, push} - {2'b0, pop};
        end
    end
endmodule

[rtl/sha_core.sv]
// Back end: block packing, padding, 64-round compression, digest output
module sha_core (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_q_valid,
    output logic            o_q_pop,
    input  sha_pkg::t_item  i_q_item,
    output logic            o_valid,
    input  logic            i_ready,
    output logic [31:0]     o_digest_word,
    output logic [2:0]      o_word_index,
    output logic            o_last_word
);
    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_PAD  = 5'b00010,
        ST_RUN  = 5'b00100,
        ST_FIN  = 5'b01000,
        ST_OUT  = 5'b10000
    } t_state;

    t_state r_state, n_state;
    sha_pkg::t_word r_h [8];
    sha_pkg::t_word r_v [8];
    sha_pkg::t_word r_w [16];
    logic [5:0]  r_pos, r_rnd;
    logic [63:0] r_len, r_flen;
    logic        r_pad_end;
    logic [3:0]  r_pad_cnt;
    logic [2:0]  r_oidx;
    logic        r_after_run_pad;

    logic        put_en;
    logic [7:0]  put_b;
    sha_pkg::t_word w_cur, t1, t2, s0, s1, w_new;

    always_comb begin
        s1 = sha_pkg::rr(r_w[14], 17) ^ sha_pkg::rr(r_w[14], 19) ^ (r_w[14] >> 10);
        s0 = sha_pkg::rr(r_w[1], 7) ^ sha_pkg::rr(r_w[1], 18) ^ (r_w[1] >> 3);
        w_new = s1 + r_w[9] + s0 + r_w[0];
        w_cur = r_w[0];
        t1 = r_v[7] + (sha_pkg::rr(r_v[4], 6) ^ sha_pkg::rr(r_v[4], 11)
             ^ sha_pkg::rr(r_v[4], 25)) + ((r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]))
             + sha_pkg::round_k(r_rnd) + w_cur;
        t2 = (sha_pkg::rr(r_v[0], 2) ^ sha_pkg::rr(r_v[0], 13) ^ sha_pkg::rr(r_v[0], 22))
             + ((r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]));
    end

    // byte source: queue item in IDLE, padding byte in PAD
    always_comb begin
        put_en = 1'b0;
        put_b  = i_q_item.data_byte;
        o_q_pop = 1'b0;
        if (r_state == ST_IDLE && i_q_valid) begin
            o_q_pop = 1'b1;
            put_en  = i_q_item.byte_present;
        end else if (r_state == ST_PAD) begin
            put_en = 1'b1;
            if (r_pad_end) put_b = 8'h00;
            else put_b = sha_pkg::PadByte;
            if (r_pad_cnt != 4'd0)
                put_b = r_flen[63:56];
        end
    end

    logic [3:0] widx;
    logic       blk_full, pad_done;
    assign widx     = r_pos[5:2];
    assign blk_full = put_en && (r_pos == 6'd63);
    assign pad_done = (r_state == ST_PAD) && (r_pad_cnt == 4'd8) && blk_full;

    assign o_valid       = (r_state == ST_OUT);
    assign o_digest_word = r_h[r_oidx];
    assign o_word_index  = r_oidx;
    assign o_last_word   = (r_oidx == 3'd7);

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: if (blk_full) n_state = ST_RUN;
                     else if (o_q_pop && i_q_item.end_of_message) n_state = ST_PAD;
            ST_PAD:  if (blk_full) n_state = ST_RUN;
            ST_RUN:  if (r_rnd == 6'd63) n_state = ST_FIN;
            ST_FIN:  n_state = r_after_run_pad ? (r_pad_cnt == 4'd9 ? ST_OUT : ST_PAD)
                                               : ST_IDLE;
            ST_OUT:  if (i_ready && r_oidx == 3'd7) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (put_en) begin
            if (r_pos[1:0] == 2'd0) r_w[widx] <= {put_b, 24'h0};
            else r_w[widx][(3 - r_pos[1:0]) * 8 +: 8] <= put_b;
        end
        if (r_state == ST_IDLE || r_state == ST_PAD) begin
            for (int i = 0; i < 8; i++) r_v[i] <= r_h[i];
        end
        if (r_state == ST_RUN) begin
            for (int i = 0; i < 15; i++) r_w[i] <= r_w[i+1];
            r_w[15] <= w_new;
            r_v[7] <= r_v[6]; r_v[6] <= r_v[5]; r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2]; r_v[2] <= r_v[1]; r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pos <= '0; r_rnd <= '0; r_len <= '0; r_flen <= '0;
            r_pad_end <= 1'b0; r_pad_cnt <= '0; r_oidx <= '0; r_after_run_pad <= 1'b0;
            for (int i = 0; i < 8; i++) r_h[i] <= sha_pkg::init_h(3'(i));
        end else begin
            r_state <= n_state;
            if (put_en) r_pos <= r_pos + 6'd1;
            if (r_state == ST_IDLE && o_q_pop) begin
                if (i_q_item.byte_present) r_len <= r_len + 64'd8;
                if (i_q_item.end_of_message) begin
                    r_flen <= r_len + (i_q_item.byte_present ? 64'd8 : 64'd0);
                    r_after_run_pad <= 1'b1;
                    r_pad_end <= 1'b0;
                    r_pad_cnt <= '0;
                end
            end
            if (r_state == ST_PAD) begin
                if (r_pad_cnt != 4'd0) begin
                    r_flen <= {r_flen[55:0], 8'h00};
                    r_pad_cnt <= r_pad_cnt + 4'd1;
                end else begin
                    r_pad_end <= 1'b1;
                    if (r_pos == sha_pkg::LenPos - 6'd1 && r_pad_end) r_pad_cnt <= 4'd1;
                    else if (r_pos == sha_pkg::LenPos - 6'd1 && !r_pad_end)
                        r_pad_cnt <= 4'd1;
                end
                if (pad_done) r_pad_cnt <= 4'd9;
            end
            if (r_state == ST_RUN) r_rnd <= r_rnd + 6'd1;
            if (r_state == ST_FIN) begin
                r_rnd <= '0;
                for (int i = 0; i < 8; i++) r_h[i] <= r_h[i] + r_v[i];
            end
            if (r_state == ST_OUT && i_ready) begin
                r_oidx <= r_oidx + 3'd1;
                if (r_oidx == 3'd7) begin
                    for (int i = 0; i < 8; i++) r_h[i] <= sha_pkg::init_h(3'(i));
                    r_len <= '0; r_pos <= '0; r_after_run_pad <= 1'b0;
                end
            end
        end
    end
endmodule

[rtl/sha_checker.sv]
// Checker: port-level properties of the SHA-256 engine
module sha_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        out_valid,
    input logic        out_ready,
    input logic [35:0] out_payload
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_payload))
        else $error("output changed while stalled");
    a_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> (out_payload[0] == (out_payload[3:1] == 3'd7)))
        else $error("last marker mismatch");
    a_next: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && out_ready && !out_payload[0] |=>
        out_valid && out_payload[3:1] == $past(out_payload[3:1]) + 3'd1)
        else $error("digest words not consecutive");
endmodule

bind sha256_hash_engine sha_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .out_valid(m_out.valid), .out_ready(m_out.ready), .out_payload(m_out.payload)
);
